// ===== rtl/lss_pkg.sv =====
// Shared widths, operation codes, register indexes and the neighbour table.
`timescale 1ns / 1ps
package lss_pkg;

    localparam int OP_W      = 3;
    localparam int DIR_W     = 4;
    localparam int POS_W     = 4;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;
    localparam int Q_W       = 4;

    localparam int EVEN_SLOTS = 10;
    localparam int ODD_SLOTS  = 9;

    localparam logic [OP_W-1:0] OP_WR_EVEN = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_ODD  = 3'd1;
    localparam logic [OP_W-1:0] OP_RD_EVEN = 3'd2;
    localparam logic [OP_W-1:0] OP_RD_ODD  = 3'd3;
    localparam logic [OP_W-1:0] OP_STREAM  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

    localparam logic [CFG_DAT_W-1:0] SIZE_RESET = 5'd16;

    typedef struct packed {
        logic signed [1:0] dx;
        logic signed [1:0] dy;
        logic signed [1:0] dz;
    } t_off;

    // Controller to datapath commands
    typedef struct packed {
        logic ld_item;
        logic set_a;
        logic set_b;
        logic set_c;
        logic host;
        logic issue;
        logic swap;
        logic ld_out;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic go;
        logic stream;
        logic q_last;
    } t_sts;

    function automatic t_off lss_nbr_off(input logic [Q_W-1:0] q);
        t_off o;
        o = '0;
        case (q)
            4'd0: o = '{dx: 2'sd1, dy: 2'sd0,  dz: 2'sd0};
            4'd1: o = '{dx: 2'sd0, dy: 2'sd1,  dz: 2'sd0};
            4'd2: o = '{dx: 2'sd0, dy: 2'sd0,  dz: 2'sd1};
            4'd3: o = '{dx: 2'sd1, dy: 2'sd1,  dz: 2'sd0};
            4'd4: o = '{dx: 2'sd1, dy: -2'sd1, dz: 2'sd0};
            4'd5: o = '{dx: 2'sd1, dy: 2'sd0,  dz: 2'sd1};
            4'd6: o = '{dx: 2'sd1, dy: 2'sd0,  dz: -2'sd1};
            4'd7: o = '{dx: 2'sd0, dy: 2'sd1,  dz: 2'sd1};
            4'd8: o = '{dx: 2'sd0, dy: 2'sd1,  dz: -2'sd1};
            default: o = '0;
        endcase
        return o;
    endfunction

endpackage

// ===== rtl/lss_if.sv =====
// Handshake channels: command item in, result item out, register writes.
`timescale 1ns / 1ps
interface lss_in_if;
    import lss_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic [DIR_W-1:0]        direction;
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic [POS_W-1:0]        pos_z;
    logic                    is_fluid;
    logic signed [VAL_W-1:0] write_value;

    modport source (output valid, operation, direction, pos_x, pos_y, pos_z, is_fluid,
                    write_value, input ready);
    modport sink (input valid, operation, direction, pos_x, pos_y, pos_z, is_fluid,
                  write_value, output ready);
endinterface

interface lss_out_if;
    import lss_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] read_value;
    logic [CNT_W-1:0]        swap_count;

    modport source (output valid, read_value, swap_count, input ready);
    modport sink (input valid, read_value, swap_count, output ready);
endinterface

interface lss_cfg_if;
    import lss_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/lss_ctrl.sv =====
// Sequencer for host accesses and the nine-pair stream walk.
`timescale 1ns / 1ps
module lss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output lss_pkg::t_cmd o_cmd,
    input  lss_pkg::t_sts i_sts
);
    import lss_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SET_A = 3'd1;
    localparam logic [2:0] S_SET_B = 3'd2;
    localparam logic [2:0] S_SET_C = 3'd3;
    localparam logic [2:0] S_HOST  = 3'd4;
    localparam logic [2:0] S_ISSUE = 3'd5;
    localparam logic [2:0] S_SWAP  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    t_cmd       cmd;

    always_comb begin
        cmd        = '0;
        n_state    = r_state;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                cmd.ld_item = i_in_valid;
                if (i_in_valid) n_state = S_SET_A;
            end
            S_SET_A: begin
                cmd.set_a = 1'b1;
                n_state   = i_sts.go ? S_SET_B : S_OUT;
            end
            S_SET_B: begin
                cmd.set_b = 1'b1;
                n_state   = S_SET_C;
            end
            S_SET_C: begin
                cmd.set_c = 1'b1;
                n_state   = i_sts.stream ? S_ISSUE : S_HOST;
            end
            S_HOST: begin
                cmd.host = 1'b1;
                n_state  = S_OUT;
            end
            S_ISSUE: begin
                cmd.issue = 1'b1;
                n_state   = S_SWAP;
            end
            S_SWAP: begin
                cmd.swap = 1'b1;
                n_state  = i_sts.q_last ? S_OUT : S_ISSUE;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    cmd.ld_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.ld_out) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/lss_datapath.sv =====
// Size registers, node address arithmetic, the two stores and the swap logic.
`timescale 1ns / 1ps
module lss_datapath #(
    parameter int MAX_DIM = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lss_pkg::t_cmd                    i_cmd,
    output lss_pkg::t_sts                    o_sts,
    input  logic                             i_cfg_we,
    input  logic [lss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lss_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    input  logic [lss_pkg::OP_W-1:0]         i_operation,
    input  logic [lss_pkg::DIR_W-1:0]        i_direction,
    input  logic [lss_pkg::POS_W-1:0]        i_pos_x,
    input  logic [lss_pkg::POS_W-1:0]        i_pos_y,
    input  logic [lss_pkg::POS_W-1:0]        i_pos_z,
    input  logic                             i_is_fluid,
    input  logic signed [lss_pkg::VAL_W-1:0] i_write_value,
    output logic signed [lss_pkg::VAL_W-1:0] o_read_value,
    output logic [lss_pkg::CNT_W-1:0]        o_swap_count
);
    import lss_pkg::*;

    localparam int NODE_CAP   = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int EVEN_DEPTH = EVEN_SLOTS * NODE_CAP;
    localparam int ODD_DEPTH  = ODD_SLOTS * NODE_CAP;
    localparam int SW         = $clog2(MAX_DIM + 1);
    localparam int CW         = (SW > CFG_DAT_W) ? SW : CFG_DAT_W;
    localparam int P2W        = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int NTW        = $clog2(NODE_CAP + 1);
    localparam int NW         = $clog2(NODE_CAP);
    localparam int EAW        = $clog2(EVEN_DEPTH);
    localparam int OAW        = $clog2(ODD_DEPTH);
    localparam int DW         = NTW + 2;

    logic [CFG_DAT_W-1:0] r_size_x;
    logic [CFG_DAT_W-1:0] r_size_y;
    logic [CFG_DAT_W-1:0] r_size_z;

    logic [OP_W-1:0]         r_op;
    logic [DIR_W-1:0]        r_dir;
    logic [POS_W-1:0]        r_x;
    logic [POS_W-1:0]        r_y;
    logic [POS_W-1:0]        r_z;
    logic signed [VAL_W-1:0] r_wval;
    logic                    r_go;

    logic [P2W-1:0] r_nxy;
    logic [P2W-1:0] r_zy;
    logic [NTW-1:0] r_tot;
    logic [NW-1:0]  r_node;
    logic [NW-1:0]  r_nb;
    logic [EAW-1:0] r_ea;
    logic [OAW-1:0] r_oa;
    logic [EAW-1:0] r_ebase;
    logic [OAW-1:0] r_obase;
    logic [Q_W-1:0] r_q;
    logic [CNT_W-1:0] r_swaps;

    logic signed [VAL_W-1:0] r_even_rd;
    logic signed [VAL_W-1:0] r_odd_rd;
    logic signed [VAL_W-1:0] r_read_value;
    logic [CNT_W-1:0]        r_swap_count;

    logic [VAL_W-1:0] mem_even [EVEN_DEPTH];
    logic [VAL_W-1:0] mem_odd  [ODD_DEPTH];

    logic [SW-1:0] nx;
    logic [SW-1:0] ny;
    logic [SW-1:0] nz;
    logic          in_range;
    logic          go_now;

    logic [Q_W-1:0]        nq;
    t_off                  off;
    logic signed [DW-1:0]  d_x;
    logic signed [DW-1:0]  d_y;
    logic signed [DW-1:0]  d_z;
    logic signed [DW-1:0]  nb_s;
    logic [NW-1:0]         nb_next;

    logic [EAW-1:0]   even_addr;
    logic [OAW-1:0]   odd_addr;
    logic             even_we;
    logic             even_re;
    logic             odd_we;
    logic             odd_re;
    logic [VAL_W-1:0] even_wd;
    logic [VAL_W-1:0] odd_wd;
    logic             positive;

    // 0 acts as 1, anything above MAX_DIM as MAX_DIM
    function automatic logic [SW-1:0] eff_size(input logic [CFG_DAT_W-1:0] s);
        logic [CW-1:0] se;
        se = CW'(s);
        if (s == '0) return SW'(1);
        if (se > CW'(MAX_DIM)) return SW'(MAX_DIM);
        return SW'(s);
    endfunction

    // Node index change for one axis step, wrapping at either face
    function automatic logic signed [DW-1:0] step_delta(
        input logic signed [1:0]    d,
        input logic                 first,
        input logic                 last,
        input logic signed [DW-1:0] stride,
        input logic signed [DW-1:0] span
    );
        logic signed [DW-1:0] delta;
        delta = '0;
        if (d > 0) delta = last ? -(span - stride) : stride;
        else if (d < 0) delta = first ? (span - stride) : -stride;
        return delta;
    endfunction

    assign nx = eff_size(r_size_x);
    assign ny = eff_size(r_size_y);
    assign nz = eff_size(r_size_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_RESET;
            r_size_y <= SIZE_RESET;
            r_size_z <= SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SIZE_X: r_size_x <= i_cfg_data;
                CFG_SIZE_Y: r_size_y <= i_cfg_data;
                CFG_SIZE_Z: r_size_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Legality of the incoming item
    always_comb begin
        in_range = (CW'(i_pos_x) < CW'(nx)) && (CW'(i_pos_y) < CW'(ny)) &&
                   (CW'(i_pos_z) < CW'(nz));
        case (i_operation)
            OP_WR_EVEN, OP_RD_EVEN: go_now = in_range && (i_direction < DIR_W'(EVEN_SLOTS));
            OP_WR_ODD, OP_RD_ODD:   go_now = in_range && (i_direction < DIR_W'(ODD_SLOTS));
            OP_STREAM:              go_now = in_range && i_is_fluid;
            default:                go_now = 1'b0;
        endcase
    end

    // Neighbour node of the next direction pair
    always_comb begin
        nq  = i_cmd.set_c ? '0 : r_q + Q_W'(1);
        off = lss_nbr_off(nq);
        d_x = step_delta(off.dx, r_x == '0, (CW'(r_x) + CW'(1)) >= CW'(nx),
                         DW'(1), $signed(DW'(nx)));
        d_y = step_delta(off.dy, r_y == '0, (CW'(r_y) + CW'(1)) >= CW'(ny),
                         $signed(DW'(nx)), $signed(DW'(r_nxy)));
        d_z = step_delta(off.dz, r_z == '0, (CW'(r_z) + CW'(1)) >= CW'(nz),
                         $signed(DW'(r_nxy)), $signed(DW'(r_tot)));
        nb_s    = $signed(DW'(r_node)) + d_x + d_y + d_z;
        nb_next = nb_s[NW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_op    <= i_operation;
            r_dir   <= i_direction;
            r_x     <= i_pos_x;
            r_y     <= i_pos_y;
            r_z     <= i_pos_z;
            r_wval  <= i_write_value;
            r_go    <= go_now;
            r_swaps <= '0;
        end
        if (i_cmd.set_a) begin
            r_nxy <= P2W'(P2W'(nx) * P2W'(ny));
            r_zy  <= P2W'(P2W'(r_z) * P2W'(ny) + P2W'(r_y));
        end
        if (i_cmd.set_b) begin
            r_node <= NW'(NTW'(r_zy) * NTW'(nx) + NTW'(r_x));
            r_tot  <= NTW'(NTW'(r_nxy) * NTW'(nz));
        end
        if (i_cmd.set_c) begin
            r_ea    <= EAW'(EAW'(r_dir) * EAW'(NODE_CAP) + EAW'(r_node));
            r_oa    <= OAW'(OAW'(r_dir) * OAW'(NODE_CAP) + OAW'(r_node));
            r_nb    <= nb_next;
            r_ebase <= EAW'(NODE_CAP);
            r_obase <= '0;
            r_q     <= '0;
        end
        if (i_cmd.issue) begin
            r_ea <= even_addr;
            r_oa <= odd_addr;
        end
        if (i_cmd.swap) begin
            r_ebase <= r_ebase + EAW'(NODE_CAP);
            r_obase <= r_obase + OAW'(NODE_CAP);
            r_q     <= r_q + Q_W'(1);
            r_nb    <= nb_next;
            if (positive) r_swaps <= r_swaps + CNT_W'(1);
        end
        if (i_cmd.ld_out) begin
            if (r_go && r_op == OP_RD_EVEN) r_read_value <= r_even_rd;
            else if (r_go && r_op == OP_RD_ODD) r_read_value <= r_odd_rd;
            else r_read_value <= '0;
            r_swap_count <= r_swaps;
        end
    end

    // Single-port stores: one access each per cycle
    assign positive  = r_even_rd > 0;
    assign even_addr = i_cmd.issue ? r_ebase + EAW'(r_nb) : r_ea;
    assign odd_addr  = i_cmd.issue ? r_obase + OAW'(r_node) : r_oa;
    assign even_re   = i_cmd.issue || (i_cmd.host && r_op == OP_RD_EVEN);
    assign odd_re    = i_cmd.issue || (i_cmd.host && r_op == OP_RD_ODD);
    assign even_we   = (i_cmd.swap && positive) || (i_cmd.host && r_op == OP_WR_EVEN);
    assign odd_we    = (i_cmd.swap && positive) || (i_cmd.host && r_op == OP_WR_ODD);
    assign even_wd   = i_cmd.swap ? r_odd_rd : r_wval;
    assign odd_wd    = i_cmd.swap ? r_even_rd : r_wval;

    always_ff @(posedge i_clk) begin
        if (even_we) mem_even[even_addr] <= even_wd;
        if (even_re) r_even_rd <= mem_even[even_addr];
    end

    always_ff @(posedge i_clk) begin
        if (odd_we) mem_odd[odd_addr] <= odd_wd;
        if (odd_re) r_odd_rd <= mem_odd[odd_addr];
    end

    assign o_sts.go     = r_go;
    assign o_sts.stream = r_op == OP_STREAM;
    assign o_sts.q_last = r_q == Q_W'(ODD_SLOTS - 1);
    assign o_read_value = r_read_value;
    assign o_swap_count = r_swap_count;

endmodule

// ===== rtl/lattice_swap_streaming.sv =====
// Host write or read: three address steps, one store access, then the result. A fluid
// stream step: the three address steps, then a read step and a write step per direction
// pair on the single-port stores. An ignored item goes from the first address step to the
// result. A new item is taken only once the result is loaded. Config writes take effect at once.
// Reset (synchronous, active low) clears the sequencer, the output valid and sets all
// sizes to 16; store contents are undefined until written.
`timescale 1ns / 1ps
module lattice_swap_streaming #(
    parameter int MAX_DIM = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lss_in_if.sink    i_item,
    lss_out_if.source o_result,
    lss_cfg_if.sink   i_cfg
);
    import lss_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign i_cfg.ready = 1'b1;

    lss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    lss_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg.valid && i_cfg.ready),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_operation   (i_item.operation),
        .i_direction   (i_item.direction),
        .i_pos_x       (i_item.pos_x),
        .i_pos_y       (i_item.pos_y),
        .i_pos_z       (i_item.pos_z),
        .i_is_fluid    (i_item.is_fluid),
        .i_write_value (i_item.write_value),
        .o_read_value  (o_result.read_value),
        .o_swap_count  (o_result.swap_count)
    );

    // busy after an item is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready |=> !i_item.ready)
        else $error("input ready straight after an accepted item");

    a_swap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> o_result.swap_count <= CNT_W'(ODD_SLOTS))
        else $error("swap count above the number of direction pairs");

    a_read_or_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.read_value != '0 |-> o_result.swap_count == '0)
        else $error("result carries both a read value and swaps");

    // a stream walk ends only in the result stage
    a_swap_then_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.swap && sts.q_last |=> !cmd.issue && !i_item.ready)
        else $error("stream walk did not close after the last pair");

endmodule
